@@ design/fuzzy_alpha_cut_and_spread_unit_macros.svh @@
// assertion macros for the fuzzy alpha cut and spread unit checker
`ifndef FUZZY_ALPHA_CUT_AND_SPREAD_UNIT_MACROS_SVH
`define FUZZY_ALPHA_CUT_AND_SPREAD_UNIT_MACROS_SVH

// same-cycle implication
`define FACS_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("facs assertion failed");

// next-cycle implication
`define FACS_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("facs assertion failed");

`endif

@@ design/facs_pkg.sv @@
// shared types, constants and helpers for the fuzzy alpha cut and spread unit
package facs_pkg;

    localparam int POS_W     = 32;
    localparam int MU_W      = 17;
    localparam int SPR_W     = 31;
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int PROD_W    = 51;
    localparam int DIV_CNT_W = 6;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALPHA  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SPREAD = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    localparam logic [MU_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [MU_W-1:0] LOW_CUT = 17'd3277;
    localparam logic [MU_W-1:0] TOP_CUT = 17'd65535;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd51;

    localparam logic signed [52:0] POS_MAX_WIDE = 53'sd2147483647;
    localparam logic signed [52:0] POS_MIN_WIDE = -53'sd2147483648;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [52:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_MAX_WIDE)
        begin
            r = POS_MAX_WIDE[POS_W-1:0];
        end
        else if (v < POS_MIN_WIDE)
        begin
            r = POS_MIN_WIDE[POS_W-1:0];
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [MU_W-1:0] sat_grade(input logic [MU_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

@@ design/fuzzy_alpha_cut_and_spread_unit.sv @@
// fuzzy membership table with alpha cut and possible spread queries
// load and unused codes leave the unit in idle, ready again the next cycle
// alpha query: scan the N points in use, then find each end; each interpolated end
// goes through read, prep, multiply and the shared 51-step restoring divider; a table end is read directly
// spread query: two cuts back to back; the result waits in ST_FINISH while the output stalls
// rst_n clears control and sets point_count to 1; the tables hold garbage until loaded
module fuzzy_alpha_cut_and_spread_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [facs_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [facs_pkg::REQ_W-1:0]          req_type,
    input  logic [facs_pkg::IDX_W-1:0]          point_index,
    input  logic signed [facs_pkg::POS_W-1:0]   point_x,
    input  logic [facs_pkg::MU_W-1:0]           point_mu,
    input  logic [facs_pkg::MU_W-1:0]           alpha,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [facs_pkg::POS_W-1:0]   left_bound,
    output logic signed [facs_pkg::POS_W-1:0]   right_bound,
    output logic [facs_pkg::SPR_W-1:0]          spread,
    output logic                                status
);
    import facs_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_END_SEL,
        ST_RD_A,
        ST_RD_B,
        ST_PREP,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIN,
        ST_STORE,
        ST_SPREAD,
        ST_FINISH
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          point_count_reg;
    logic                      spread_mode_reg;
    logic                      top_cut_reg;
    logic                      side_right_reg;
    logic [MU_W-1:0]           lvl_reg;
    logic [IW-1:0]             n_last_reg;
    logic [IW-1:0]             scan_idx_reg;
    logic [IW-1:0]             chk_idx_reg;
    logic                      chk_vld_reg;
    logic                      found_reg;
    logic                      found1_reg;
    logic [IW-1:0]             first_reg;
    logic [IW-1:0]             last_reg;
    logic [IW-1:0]             a_idx_reg;
    logic [IW-1:0]             b_idx_reg;
    logic                      end_reg;
    logic signed [POS_W-1:0]   xa_reg;
    logic [MU_W-1:0]           ma_reg;
    logic signed [POS_W:0]     dx_reg;
    logic signed [MU_W:0]      dm_reg;
    logic signed [MU_W:0]      dl_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]         quo_reg;
    logic [MU_W-1:0]           rem_reg;
    logic [MU_W-1:0]           dvs_reg;
    logic                      neg_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic signed [POS_W-1:0]   res_reg;
    logic signed [POS_W-1:0]   l0_reg;
    logic signed [POS_W-1:0]   r0_reg;
    logic signed [POS_W-1:0]   l1_reg;
    logic signed [POS_W-1:0]   r1_reg;
    logic [SPR_W-1:0]          spr_reg;
    logic                      empty_reg;
    logic                      out_valid_reg;
    logic signed [POS_W-1:0]   left_bound_reg;
    logic signed [POS_W-1:0]   right_bound_reg;
    logic [SPR_W-1:0]          spread_reg;
    logic                      status_reg;

    logic signed [POS_W-1:0]   pos_mem [MAX_POINTS];
    logic [MU_W-1:0]           mu_mem  [MAX_POINTS];
    logic signed [POS_W-1:0]   rd_pos_reg;
    logic [MU_W-1:0]           rd_mu_reg;
    logic [IW-1:0]             rd_addr;

    logic                      in_fire;
    logic                      load_we;
    logic [IW-1:0]             load_addr;
    logic [31:0]               pc_wide;
    logic [31:0]               n_eff_wide;
    logic [31:0]               n_last_wide;
    logic                      hit;
    logic [MU_W:0]             rem_sh;
    logic                      sub_ok;
    logic [MU_W:0]             rem_sub;
    logic [PROD_W-1:0]         prod_abs;
    logic [MU_W:0]             dm_neg;
    logic [MU_W-1:0]           dm_abs;
    logic signed [PROD_W:0]    q_signed;
    logic signed [52:0]        interp_sum;
    logic signed [33:0]        s_top;
    logic signed [33:0]        s_flat;
    logic signed [33:0]        s_sel;
    logic signed [33:0]        s_adj;
    logic signed [33:0]        s_quo;
    logic [SPR_W-1:0]          s_sat;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign left_bound  = left_bound_reg;
    assign right_bound = right_bound_reg;
    assign spread      = spread_reg;
    assign status      = status_reg;

    assign load_addr = IW'(point_index);
    assign load_we   = in_fire && (req_type == REQ_LOAD)
                       && ({26'd0, point_index} < 32'(MAX_POINTS));

    assign pc_wide     = {25'd0, point_count_reg};
    assign n_eff_wide  = (pc_wide == 32'd0) ? 32'd1 :
                         ((pc_wide > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : pc_wide);
    assign n_last_wide = n_eff_wide - 32'd1;

    assign hit = chk_vld_reg && (rd_mu_reg >= lvl_reg);

    assign rem_sh  = {rem_reg, quo_reg[PROD_W-1]};
    assign sub_ok  = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    assign prod_abs = prod_reg[PROD_W-1] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign dm_neg   = $unsigned(-dm_reg);
    assign dm_abs   = dm_reg[MU_W] ? dm_neg[MU_W-1:0] : dm_reg[MU_W-1:0];

    assign q_signed   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign interp_sum = $signed({{21{xa_reg[POS_W-1]}}, xa_reg})
                        + $signed({q_signed[PROD_W], q_signed});

    assign s_top  = ($signed({{2{l1_reg[POS_W-1]}}, l1_reg}) - $signed({{2{l0_reg[POS_W-1]}}, l0_reg}))
                  + ($signed({{2{r0_reg[POS_W-1]}}, r0_reg}) - $signed({{2{r1_reg[POS_W-1]}}, r1_reg}));
    assign s_flat = $signed({{2{r0_reg[POS_W-1]}}, r0_reg}) - $signed({{2{l0_reg[POS_W-1]}}, l0_reg});
    assign s_sel  = found1_reg ? s_top : s_flat;
    assign s_adj  = s_sel + (s_sel[33] ? 34'sd3 : 34'sd0);
    assign s_quo  = s_adj >>> 2;
    assign s_sat  = s_quo[33] ? '0 :
                    ((s_quo[32:31] != 2'b00) ? {SPR_W{1'b1}} : s_quo[SPR_W-1:0]);

    always_comb
    begin
        case (state_reg)
            ST_SCAN: rd_addr = scan_idx_reg;
            ST_RD_A: rd_addr = a_idx_reg;
            ST_RD_B: rd_addr = b_idx_reg;
            default: rd_addr = a_idx_reg;
        endcase
    end

    // point tables, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            pos_mem[load_addr] <= point_x;
            mu_mem[load_addr]  <= sat_grade(point_mu);
        end
        rd_pos_reg <= pos_mem[rd_addr];
        rd_mu_reg  <= mu_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= 7'd1;
            spread_mode_reg <= 1'b0;
            top_cut_reg     <= 1'b0;
            side_right_reg  <= 1'b0;
            lvl_reg         <= '0;
            n_last_reg      <= '0;
            scan_idx_reg    <= '0;
            chk_idx_reg     <= '0;
            chk_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            found1_reg      <= 1'b0;
            first_reg       <= '0;
            last_reg        <= '0;
            a_idx_reg       <= '0;
            b_idx_reg       <= '0;
            end_reg         <= 1'b0;
            xa_reg          <= '0;
            ma_reg          <= '0;
            dx_reg          <= '0;
            dm_reg          <= '0;
            dl_reg          <= '0;
            prod_reg        <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            dvs_reg         <= '0;
            neg_reg         <= 1'b0;
            div_cnt_reg     <= '0;
            res_reg         <= '0;
            l0_reg          <= '0;
            r0_reg          <= '0;
            l1_reg          <= '0;
            r1_reg          <= '0;
            spr_reg         <= '0;
            empty_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            left_bound_reg  <= '0;
            right_bound_reg <= '0;
            spread_reg      <= '0;
            status_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                point_count_reg <= cfg_wdata;
            end
            // in ST_FINISH the output register is handled below
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (req_type == REQ_ALPHA || req_type == REQ_SPREAD))
                    begin
                        spread_mode_reg <= (req_type == REQ_SPREAD);
                        top_cut_reg     <= 1'b0;
                        lvl_reg         <= (req_type == REQ_SPREAD) ? LOW_CUT : sat_grade(alpha);
                        n_last_reg      <= n_last_wide[IW-1:0];
                        scan_idx_reg    <= '0;
                        chk_vld_reg     <= 1'b0;
                        found_reg       <= 1'b0;
                        state_reg       <= ST_SCAN;
                    end
                end

                ST_SCAN, ST_SCAN_LAST:
                begin
                    if (hit)
                    begin
                        if (!found_reg)
                        begin
                            first_reg <= chk_idx_reg;
                        end
                        last_reg  <= chk_idx_reg;
                        found_reg <= 1'b1;
                    end
                    if (state_reg == ST_SCAN)
                    begin
                        chk_idx_reg <= scan_idx_reg;
                        chk_vld_reg <= 1'b1;
                        if (scan_idx_reg == n_last_reg)
                        begin
                            state_reg <= ST_SCAN_LAST;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                        state_reg   <= ST_END_SEL;
                    end
                end

                ST_END_SEL:
                begin
                    if (!found_reg)
                    begin
                        if (top_cut_reg)
                        begin
                            found1_reg <= 1'b0;
                            state_reg  <= ST_SPREAD;
                        end
                        else
                        begin
                            empty_reg <= 1'b1;
                            l0_reg    <= '0;
                            r0_reg    <= '0;
                            spr_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                    end
                    else
                    begin
                        side_right_reg <= 1'b0;
                        if (first_reg == '0)
                        begin
                            end_reg   <= 1'b1;
                            a_idx_reg <= first_reg;
                        end
                        else
                        begin
                            end_reg   <= 1'b0;
                            a_idx_reg <= first_reg - 1'b1;
                            b_idx_reg <= first_reg;
                        end
                        state_reg <= ST_RD_A;
                    end
                end

                ST_RD_A:
                begin
                    state_reg <= ST_RD_B;
                end

                ST_RD_B:
                begin
                    if (end_reg)
                    begin
                        res_reg   <= rd_pos_reg;
                        state_reg <= ST_STORE;
                    end
                    else
                    begin
                        xa_reg    <= rd_pos_reg;
                        ma_reg    <= rd_mu_reg;
                        state_reg <= ST_PREP;
                    end
                end

                ST_PREP:
                begin
                    dx_reg    <= $signed({rd_pos_reg[POS_W-1], rd_pos_reg})
                               - $signed({xa_reg[POS_W-1], xa_reg});
                    dm_reg    <= $signed({1'b0, rd_mu_reg}) - $signed({1'b0, ma_reg});
                    dl_reg    <= $signed({1'b0, lvl_reg}) - $signed({1'b0, ma_reg});
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    prod_reg  <= dl_reg * dx_reg;
                    state_reg <= ST_DIV_INIT;
                end

                ST_DIV_INIT:
                begin
                    if (dm_reg == '0)
                    begin
                        res_reg   <= xa_reg;
                        state_reg <= ST_STORE;
                    end
                    else
                    begin
                        quo_reg     <= prod_abs;
                        rem_reg     <= '0;
                        dvs_reg     <= dm_abs;
                        neg_reg     <= prod_reg[PROD_W-1] ^ dm_reg[MU_W];
                        div_cnt_reg <= DIV_STEPS;
                        state_reg   <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (sub_ok)
                    begin
                        rem_reg <= rem_sub[MU_W-1:0];
                        quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[MU_W-1:0];
                        quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == 6'd1)
                    begin
                        state_reg <= ST_DIV_FIN;
                    end
                end

                ST_DIV_FIN:
                begin
                    res_reg   <= sat_pos(interp_sum);
                    state_reg <= ST_STORE;
                end

                ST_STORE:
                begin
                    if (!side_right_reg)
                    begin
                        if (top_cut_reg)
                        begin
                            l1_reg <= res_reg;
                        end
                        else
                        begin
                            l0_reg <= res_reg;
                        end
                        side_right_reg <= 1'b1;
                        a_idx_reg      <= last_reg;
                        if (last_reg == n_last_reg)
                        begin
                            end_reg <= 1'b1;
                        end
                        else
                        begin
                            end_reg   <= 1'b0;
                            b_idx_reg <= last_reg + 1'b1;
                        end
                        state_reg <= ST_RD_A;
                    end
                    else if (top_cut_reg)
                    begin
                        r1_reg     <= res_reg;
                        found1_reg <= 1'b1;
                        state_reg  <= ST_SPREAD;
                    end
                    else
                    begin
                        r0_reg <= res_reg;
                        if (spread_mode_reg)
                        begin
                            top_cut_reg  <= 1'b1;
                            lvl_reg      <= TOP_CUT;
                            scan_idx_reg <= '0;
                            chk_vld_reg  <= 1'b0;
                            found_reg    <= 1'b0;
                            state_reg    <= ST_SCAN;
                        end
                        else
                        begin
                            empty_reg <= 1'b0;
                            spr_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                    end
                end

                ST_SPREAD:
                begin
                    spr_reg   <= s_sat;
                    empty_reg <= 1'b0;
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        left_bound_reg  <= l0_reg;
                        right_bound_reg <= r0_reg;
                        spread_reg      <= spr_reg;
                        status_reg      <= empty_reg;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                    else if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/facs_checker.sv @@
// port-level checker for the fuzzy alpha cut and spread unit, with its bind
`include "fuzzy_alpha_cut_and_spread_unit_macros.svh"

module facs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [facs_pkg::REQ_W-1:0]          req_type,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [facs_pkg::POS_W-1:0]   left_bound,
    input logic signed [facs_pkg::POS_W-1:0]   right_bound,
    input logic [facs_pkg::SPR_W-1:0]          spread,
    input logic                                status
);
    import facs_pkg::*;

    `FACS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_bound) && $stable(right_bound) && $stable(spread) && $stable(status))
    `FACS_ASSERT_NOW(a_empty_zero, out_valid && status, left_bound == 0 && right_bound == 0 && spread == 0)
    `FACS_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (req_type == REQ_ALPHA || req_type == REQ_SPREAD), !in_ready)
    `FACS_ASSERT_NEXT(a_load_quick, in_valid && in_ready && (req_type == REQ_LOAD || req_type == REQ_NONE), in_ready)

endmodule

bind fuzzy_alpha_cut_and_spread_unit facs_checker u_facs_checker (.*);
